@@ hw/rtl/cplc_pkg.sv @@
// Shared constants for the coordinate parse and line conflict check unit.
`default_nettype none

package cplc_pkg;

    // Default coordinate limit (rows and columns run 0 .. MAX_COORD-1)
    localparam int unsigned MAX_COORD_DEF = 1024;

    // Set tag width kept per map entry
    localparam int unsigned EPOCH_W = 8;

    // Field widths
    localparam int unsigned CH_W       = 8;
    localparam int unsigned OUT_W      = 11;
    localparam int unsigned IN_TDATA_W = 8;
    localparam int unsigned OUT_TDATA_W = 32;

    // Character classes
    localparam logic [CH_W-1:0] CH_LOWER_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [CH_W-1:0] CH_DIGIT_0  = 8'h30;
    localparam logic [CH_W-1:0] CH_DIGIT_9  = 8'h39;
    localparam logic [CH_W-1:0] LETTER_BASE = 8'd96;

    // Radices of the column and row numbers
    localparam int unsigned RADIX_COL = 26;
    localparam int unsigned RADIX_ROW = 10;

    // Tag written by the clearing pass; live sets use tags from 1 up
    localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

endpackage

`default_nettype wire

@@ hw/rtl/coordinate_parse_and_line_conflict_check_unit.sv @@
// Top level of the coordinate parse and line conflict check unit.
//
// Characters stream in up to one per cycle on the slave side (tdata = character, tlast = last
// character of a coordinate, tuser = coordinate closes the set). Lower-case letters build a
// bijective base-26 column, digits a decimal row until any other character stops the row;
// both saturate at MAX_COORD. The last character of a coordinate produces one result that is
// valid on the master side once the input register has taken it, the lookup stage has loaded it
// while reading the row/column maps, and the result register has loaded it in turn. One character
// is taken every cycle while s_axis_tready is high. The row-seen and column-seen maps are
// MAX_COORD-entry memories holding a set tag per entry, so a set ends without clearing them;
// a clearing pass over all MAX_COORD entries runs after reset and again after every 255 sets when
// the tag wraps. During that pass the last character of a coordinate waits in the input
// register and further characters are held off.
`default_nettype none

module coordinate_parse_and_line_conflict_check_unit #(
    parameter int unsigned MAX_COORD = cplc_pkg::MAX_COORD_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // tdata: [7:0] ch
    input  wire logic [cplc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tlast: end_of_coord
    input  wire logic                                s_axis_tlast,
    // tuser: end_of_set
    input  wire logic                                s_axis_tuser,
    // tdata: [10:0] column, [21:11] row_num, [22] conflict, [23] out_of_range,
    //        [24] all_safe, [31:25] zero
    output logic [cplc_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tlast: last_of_set
    output logic                                     m_axis_tlast
);

    localparam int unsigned ACC_W   = $clog2(MAX_COORD + 1);
    localparam int unsigned AW      = $clog2(MAX_COORD);
    localparam int unsigned MAC_W   = ACC_W + 5;
    localparam int unsigned EPOCH_W = cplc_pkg::EPOCH_W;
    localparam int unsigned OUT_W   = cplc_pkg::OUT_W;
    localparam int unsigned CH_W    = cplc_pkg::CH_W;
    localparam int unsigned PAD_W   = cplc_pkg::OUT_TDATA_W - 2 * OUT_W - 3;

    localparam logic [ACC_W-1:0] ACC_MAX  = ACC_W'(MAX_COORD);
    localparam logic [MAC_W-1:0] MAC_MAX  = MAC_W'(MAX_COORD);
    localparam logic [AW-1:0]    ADDR_END = AW'(MAX_COORD - 1);

    // Input register
    logic            r_s1_valid;
    logic [CH_W-1:0] r_s1_ch;
    logic            r_s1_eoc;
    logic            r_s1_eos;

    // Accumulators of the coordinate in progress
    logic [ACC_W-1:0] r_col;
    logic [ACC_W-1:0] r_row;
    logic             r_stopped;

    // Map lookup stage
    logic             r_s2_valid;
    logic [ACC_W-1:0] r_s2_col;
    logic [ACC_W-1:0] r_s2_row;
    logic             r_s2_col_in;
    logic             r_s2_row_in;
    logic             r_s2_eos;

    // Set state and clearing pass
    logic               r_safe;
    logic [EPOCH_W-1:0] r_epoch;
    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_addr;

    // Result register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_col;
    logic [OUT_W-1:0] r_out_row;
    logic             r_out_conflict;
    logic             r_out_oor;
    logic             r_out_safe;
    logic             r_out_last;

    logic             is_lower;
    logic             is_digit;
    logic [MAC_W-1:0] col_mac;
    logic [MAC_W-1:0] row_mac;
    logic [ACC_W-1:0] n_col;
    logic [ACC_W-1:0] n_row;
    logic             n_stopped;
    logic             col_in;
    logic             row_in;
    logic             s1_adv;
    logic             s2_leave;
    logic             wrap_now;
    logic             s2_load_ok;
    logic             s2_load;
    logic             row_hit;
    logic             col_hit;
    logic             conflict;
    logic             oor;
    logic             safe_now;
    logic             row_wr_en;
    logic             col_wr_en;
    logic [AW-1:0]    row_wr_addr;
    logic [AW-1:0]    col_wr_addr;
    logic [EPOCH_W-1:0] wr_tag;
    logic [AW-1:0]    row_rd_addr;
    logic [AW-1:0]    col_rd_addr;

    // Classify the character and step both accumulators
    always_comb begin
        is_lower = (r_s1_ch >= cplc_pkg::CH_LOWER_A) && (r_s1_ch <= cplc_pkg::CH_LOWER_Z);
        is_digit = (r_s1_ch >= cplc_pkg::CH_DIGIT_0) && (r_s1_ch <= cplc_pkg::CH_DIGIT_9);
        col_mac  = MAC_W'(r_col) * MAC_W'(cplc_pkg::RADIX_COL)
                 + MAC_W'(r_s1_ch - cplc_pkg::LETTER_BASE);
        row_mac  = MAC_W'(r_row) * MAC_W'(cplc_pkg::RADIX_ROW)
                 + MAC_W'(r_s1_ch - cplc_pkg::CH_DIGIT_0);
        n_col = r_col;
        n_row = r_row;
        if (is_lower) begin
            n_col = (col_mac >= MAC_MAX) ? ACC_MAX : col_mac[ACC_W-1:0];
        end
        if (is_digit && !r_stopped) begin
            n_row = (row_mac >= MAC_MAX) ? ACC_MAX : row_mac[ACC_W-1:0];
        end
        n_stopped = r_stopped | (!is_lower && !is_digit);
        col_in    = n_col < ACC_MAX;
        row_in    = n_row < ACC_MAX;
    end

    // Pipeline flow control
    assign s2_leave   = r_s2_valid && (!r_out_valid || m_axis_tready);
    assign wrap_now   = s2_leave && r_s2_eos && (r_epoch == {EPOCH_W{1'b1}});
    assign s2_load_ok = !r_clr_busy && (!r_s2_valid || (s2_leave && !wrap_now));
    assign s2_load    = r_s1_valid && r_s1_eoc && s2_load_ok;
    assign s1_adv     = r_s1_valid && (!r_s1_eoc || s2_load_ok);
    assign s_axis_tready = i_rst_n && (!r_s1_valid || s1_adv);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_s1_ch  <= s_axis_tdata[CH_W-1:0];
            r_s1_eoc <= s_axis_tlast;
            r_s1_eos <= s_axis_tuser;
        end
    end

    // Advance accumulators; restart them after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_stopped <= 1'b0;
        end else if (s1_adv) begin
            if (r_s1_eoc) begin
                r_col     <= '0;
                r_row     <= '0;
                r_stopped <= 1'b0;
            end else begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_stopped <= n_stopped;
            end
        end
    end

    // Map lookup stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_load) begin
            r_s2_valid <= 1'b1;
        end else if (s2_leave) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_s2_col    <= n_col;
            r_s2_row    <= n_row;
            r_s2_col_in <= col_in;
            r_s2_row_in <= row_in;
            r_s2_eos    <= r_s1_eos;
        end
    end

    // Map ports: clearing pass or the completing coordinate writes
    assign row_rd_addr = row_in ? n_row[AW-1:0] : '0;
    assign col_rd_addr = col_in ? n_col[AW-1:0] : '0;
    assign row_wr_en   = r_clr_busy || (s2_leave && r_s2_row_in);
    assign col_wr_en   = r_clr_busy || (s2_leave && r_s2_col_in);
    assign row_wr_addr = r_clr_busy ? r_clr_addr : r_s2_row[AW-1:0];
    assign col_wr_addr = r_clr_busy ? r_clr_addr : r_s2_col[AW-1:0];
    assign wr_tag      = r_clr_busy ? cplc_pkg::EPOCH_CLEAR : r_epoch;

    cplc_line_map #(
        .DEPTH (MAX_COORD),
        .AW    (AW)
    ) u_row_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s2_load),
        .i_rd_addr (row_rd_addr),
        .i_wr_en   (row_wr_en),
        .i_wr_addr (row_wr_addr),
        .i_wr_tag  (wr_tag),
        .i_epoch   (r_epoch),
        .o_hit     (row_hit)
    );

    cplc_line_map #(
        .DEPTH (MAX_COORD),
        .AW    (AW)
    ) u_col_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s2_load),
        .i_rd_addr (col_rd_addr),
        .i_wr_en   (col_wr_en),
        .i_wr_addr (col_wr_addr),
        .i_wr_tag  (wr_tag),
        .i_epoch   (r_epoch),
        .o_hit     (col_hit)
    );

    // Conflict and safety of this coordinate
    assign conflict = (r_s2_row_in && row_hit) || (r_s2_col_in && col_hit);
    assign oor      = !r_s2_row_in || !r_s2_col_in;
    assign safe_now = r_safe && !conflict && !oor;

    // Track safety and set tag; start a clearing pass on tag wrap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safe     <= 1'b1;
            r_epoch    <= cplc_pkg::EPOCH_FIRST;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (s2_leave) begin
                r_safe <= r_s2_eos ? 1'b1 : safe_now;
            end
            if (wrap_now) begin
                r_epoch    <= cplc_pkg::EPOCH_FIRST;
                r_clr_busy <= 1'b1;
                r_clr_addr <= '0;
            end else if (s2_leave && r_s2_eos) begin
                r_epoch <= r_epoch + EPOCH_W'(1);
            end else if (r_clr_busy) begin
                if (r_clr_addr == ADDR_END) begin
                    r_clr_busy <= 1'b0;
                    r_clr_addr <= '0;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_leave) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_leave) begin
            r_out_col      <= OUT_W'(r_s2_col);
            r_out_row      <= OUT_W'(r_s2_row);
            r_out_conflict <= conflict;
            r_out_oor      <= oor;
            r_out_safe     <= safe_now;
            r_out_last     <= r_s2_eos;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_safe, r_out_oor, r_out_conflict,
                            r_out_row, r_out_col};

    // No coordinate enters the lookup stage while the maps are being cleared
    a_no_load_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !s2_load)
        else $error("coordinate entered map lookup during clearing pass");

    // Lookup stage stays empty while clearing
    a_s2_empty_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s2_valid)
        else $error("lookup stage busy during clearing pass");

    // A safe result never carries a conflict or range error
    a_safe_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_safe) |-> (!r_out_conflict && !r_out_oor))
        else $error("all_safe set with conflict or out_of_range");

    // A row outside the map always has a saturated accumulator
    a_oor_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !r_s2_row_in) |-> (r_s2_row == ACC_MAX))
        else $error("row out of range without saturation");

    // The clearing tag is never a live set tag
    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != cplc_pkg::EPOCH_CLEAR)
        else $error("set tag collides with cleared entries");

endmodule

`default_nettype wire

@@ hw/rtl/cplc_line_map.sv @@
// Line-seen map: set-tagged memory with registered read and write forwarding.
`default_nettype none

module cplc_line_map #(
    parameter int unsigned DEPTH = cplc_pkg::MAX_COORD_DEF,
    parameter int unsigned AW    = $clog2(cplc_pkg::MAX_COORD_DEF)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_rd_en,
    input  wire logic [AW-1:0]                i_rd_addr,
    input  wire logic                         i_wr_en,
    input  wire logic [AW-1:0]                i_wr_addr,
    input  wire logic [cplc_pkg::EPOCH_W-1:0] i_wr_tag,
    input  wire logic [cplc_pkg::EPOCH_W-1:0] i_epoch,
    output logic                              o_hit
);

    logic [cplc_pkg::EPOCH_W-1:0] r_mem [DEPTH];
    logic [cplc_pkg::EPOCH_W-1:0] r_rd_tag;
    logic [AW-1:0]                r_rd_addr;
    logic                         r_fwd_v;
    logic [AW-1:0]                r_fwd_addr;
    logic [cplc_pkg::EPOCH_W-1:0] r_fwd_tag;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_tag;
        end
    end

    // Registered read; old data when the same edge writes
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_tag  <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // Capture the write that lands on the read edge; the read missed it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_v <= i_wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_addr <= i_wr_addr;
            r_fwd_tag  <= i_wr_tag;
        end
    end

    // Entry is taken when its tag belongs to the current set
    assign o_hit = (r_rd_tag == i_epoch)
                || (r_fwd_v && (r_fwd_addr == r_rd_addr) && (r_fwd_tag == i_epoch));

endmodule

`default_nettype wire
